FILE: rtl/core/gcbf_pkg.sv
// Shared types and constants for the Gray-chromosome Booth fitness core.
// Used by gcbf_front, gcbf_div_cell and the top level; no dependencies.
package gcbf_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned BOOTH_W = 35;
  localparam int unsigned QUO_W   = 17;   // fitness, 65536 means one
  localparam int unsigned DIV_W   = 36;   // 2^24 + booth
  localparam int unsigned REM_W   = 41;   // holds the dividend 2^40

  localparam logic [REM_W-1:0] REM_INIT = {1'b1, {(REM_W-1){1'b0}}};
  localparam logic [DIV_W-1:0] ONE_Q24  = 36'h0_0100_0000;
  localparam logic signed [18:0] OFS_A  = 19'sd28672;  // 7.0 in Q.12
  localparam logic signed [18:0] OFS_B  = 19'sd20480;  // 5.0 in Q.12

  typedef struct packed {
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic [BOOTH_W-1:0]        booth;
  } gcbf_res_t;

  typedef struct packed {
    gcbf_res_t          res;
    logic [REM_W-1:0]   rem;
    logic [DIV_W-1:0]   dvs;
    logic [QUO_W-1:0]   quo;
  } gcbf_cell_t;

endpackage

FILE: rtl/core/gcbf_front.sv
// Front pipeline: Gray decode, Q4.12 scaling, Booth terms, squares and divisor.
// Four elastic stages; depends on gcbf_pkg.
module gcbf_front #(
  parameter int unsigned CHROMOSOME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  input  logic [31:0]         up_chromosome,
  output logic                up_ready,
  output logic                dn_valid,
  output gcbf_pkg::gcbf_cell_t dn_data,
  input  logic                dn_ready
);

  localparam int unsigned HALF = CHROMOSOME_BITS / 2;
  localparam int unsigned LOW  = CHROMOSOME_BITS - HALF;
  localparam int unsigned RSH  = (HALF >= 16) ? HALF - 16 : 0;
  localparam int unsigned LSH  = (HALF < 16) ? 16 - HALF : 0;
  localparam logic [64:0] CB_ONE  = 65'd1 << CHROMOSOME_BITS;
  localparam logic [63:0] CB_MASK = CB_ONE[63:0] - 64'd1;
  localparam logic [63:0] LO_MASK = (64'd1 << LOW) - 64'd1;

  logic [3:0] valid_r;
  logic [3:0] rdy;

  assign rdy[3]   = !valid_r[3] || dn_ready;
  assign rdy[2]   = !valid_r[2] || rdy[3];
  assign rdy[1]   = !valid_r[1] || rdy[2];
  assign rdy[0]   = !valid_r[0] || rdy[1];
  assign up_ready = rdy[0];
  assign dn_valid = valid_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (rdy[0]) valid_r[0] <= up_valid;
      if (rdy[1]) valid_r[1] <= valid_r[0];
      if (rdy[2]) valid_r[2] <= valid_r[1];
      if (rdy[3]) valid_r[3] <= valid_r[2];
    end
  end

  // stage 0: decode and scale
  logic [63:0] bin;
  logic [63:0] xraw, yraw, xsh, ysh;
  logic signed [15:0] x_nxt, y_nxt;
  logic signed [15:0] x0_r, y0_r;

  always_comb begin
    bin = {32'd0, up_chromosome} & CB_MASK;
    // prefix XOR from the top bit down the whole string
    bin = bin ^ (bin >> 1);
    bin = bin ^ (bin >> 2);
    bin = bin ^ (bin >> 4);
    bin = bin ^ (bin >> 8);
    bin = bin ^ (bin >> 16);
    bin = bin ^ (bin >> 32);
    xraw = bin >> LOW;
    yraw = bin & LO_MASK;
    xsh  = (xraw >> RSH) << LSH;
    ysh  = (yraw >> RSH) << LSH;
    // subtracting 32768 from a 17-bit value: flip bit 15, saturate y when bit 16 set
    x_nxt = {~xsh[15], xsh[14:0]};
    y_nxt = ysh[16] ? 16'sh7FFF : {~ysh[15], ysh[14:0]};
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x0_r <= x_nxt;
      y0_r <= y_nxt;
    end
  end

  // stage 1: Booth terms in Q.12
  logic signed [18:0] ta_nxt, tb_nxt, ta_r, tb_r;
  logic signed [15:0] x1_r, y1_r;

  always_comb begin
    ta_nxt = {{3{x0_r[15]}}, x0_r} + {{2{y0_r[15]}}, y0_r, 1'b0} - gcbf_pkg::OFS_A;
    tb_nxt = {{2{x0_r[15]}}, x0_r, 1'b0} + {{3{y0_r[15]}}, y0_r} - gcbf_pkg::OFS_B;
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      ta_r <= ta_nxt;
      tb_r <= tb_nxt;
      x1_r <= x0_r;
      y1_r <= y0_r;
    end
  end

  // stage 2: squares
  logic signed [37:0] sqa, sqb;
  logic [gcbf_pkg::BOOTH_W-1:0] sa_r, sb_r;
  logic signed [15:0] x2_r, y2_r;

  assign sqa = ta_r * ta_r;
  assign sqb = tb_r * tb_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      sa_r <= sqa[gcbf_pkg::BOOTH_W-1:0];
      sb_r <= sqb[gcbf_pkg::BOOTH_W-1:0];
      x2_r <= x1_r;
      y2_r <= y1_r;
    end
  end

  // stage 3: booth sum and divisor
  logic [gcbf_pkg::BOOTH_W-1:0] booth_nxt;
  gcbf_pkg::gcbf_cell_t out_r;

  assign booth_nxt = sa_r + sb_r;

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      out_r.res.coord_x <= x2_r;
      out_r.res.coord_y <= y2_r;
      out_r.res.booth   <= booth_nxt;
      out_r.rem         <= gcbf_pkg::REM_INIT;
      out_r.dvs         <= {1'b0, booth_nxt} + gcbf_pkg::ONE_Q24;
      out_r.quo         <= '0;
    end
  end

  assign dn_data = out_r;

endmodule

FILE: rtl/core/gcbf_div_cell.sv
// One restoring-division cell: resolves quotient bit SHIFT and passes the rest on.
// Elastic single-entry stage; depends on gcbf_pkg.
module gcbf_div_cell #(
  parameter int unsigned SHIFT = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  gcbf_pkg::gcbf_cell_t up_data,
  output logic                 up_ready,
  output logic                 dn_valid,
  output gcbf_pkg::gcbf_cell_t dn_data,
  input  logic                 dn_ready
);

  localparam int unsigned CMP_W = gcbf_pkg::DIV_W + gcbf_pkg::QUO_W;

  logic                 valid_r;
  gcbf_pkg::gcbf_cell_t data_r, data_nxt;
  logic [CMP_W-1:0]     dshift, rem_ext, diff;
  logic                 take;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    dshift  = {{gcbf_pkg::QUO_W{1'b0}}, up_data.dvs} << SHIFT;
    rem_ext = {{(CMP_W-gcbf_pkg::REM_W){1'b0}}, up_data.rem};
    diff    = rem_ext - dshift;
    take    = rem_ext >= dshift;
    data_nxt = up_data;
    data_nxt.rem = take ? diff[gcbf_pkg::REM_W-1:0] : up_data.rem;
    data_nxt.quo[SHIFT] = take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

FILE: rtl/core/gray_chromosome_booth_fitness_core.sv
// Gray-chromosome Booth fitness core: top level, front pipeline plus divider chain.
// Depends on gcbf_pkg, gcbf_front and gcbf_div_cell.
//
// Accepts one chromosome per cycle while in_stall is low and returns one transaction per
// chromosome, in order, with decoded x and y (Q4.12), the Booth value (Q.24) and the
// fitness floor(2^40 / (2^24 + booth)) as Q1.16. The path is four front stages
// (decode, Booth terms, squares, divisor) followed by a chain of 17 division cells,
// each resolving one quotient bit per cycle unless stalled. Every stage is elastic,
// so a stalled result only holds back the stages behind it and empty stages still
// fill; sustained throughput is one transaction per cycle when out_stall is low.
// Chromosome bits at and above CHROMOSOME_BITS are ignored.
module gray_chromosome_booth_fitness_core #(
  parameter int unsigned CHROMOSOME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_chromosome,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_coord_x,
  output logic signed [15:0] out_coord_y,
  output logic [34:0] out_booth_value,
  output logic [16:0] out_fitness_value
);

  localparam int unsigned NCELL = gcbf_pkg::QUO_W;

  gcbf_pkg::gcbf_cell_t bus   [NCELL+1];
  logic                 vld   [NCELL+1];
  logic                 rdy   [NCELL+1];
  logic                 front_ready;

  gcbf_front #(
    .CHROMOSOME_BITS(CHROMOSOME_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (in_valid),
    .up_chromosome(in_chromosome),
    .up_ready     (front_ready),
    .dn_valid     (vld[0]),
    .dn_data      (bus[0]),
    .dn_ready     (rdy[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    gcbf_div_cell #(
      .SHIFT(NCELL - 1 - k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_valid(vld[k]),
      .up_data (bus[k]),
      .up_ready(rdy[k]),
      .dn_valid(vld[k+1]),
      .dn_data (bus[k+1]),
      .dn_ready(rdy[k+1])
    );
  end

  assign rdy[NCELL] = !out_stall;
  assign in_stall   = !front_ready;

  assign out_valid         = vld[NCELL];
  assign out_coord_x       = bus[NCELL].res.coord_x;
  assign out_coord_y       = bus[NCELL].res.coord_y;
  assign out_booth_value   = bus[NCELL].res.booth;
  assign out_fitness_value = bus[NCELL].quo;

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench for gray_chromosome_booth_fitness_core: Gray decode, Booth value and fitness.
// Depends on gcbf_pkg and the core RTL; self-checking against its own scoring function.
module tb;

  localparam int CHROM_BITS = 32;
  localparam int HALF_BITS  = CHROM_BITS / 2;
  localparam int LOW_BITS   = CHROM_BITS - HALF_BITS;
  localparam int TIMEOUT_CYCLES = 200000;

  typedef struct {
    logic signed [gcbf_pkg::COORD_W-1:0] coord_x;
    logic signed [gcbf_pkg::COORD_W-1:0] coord_y;
    logic [gcbf_pkg::BOOTH_W-1:0]        booth;
    logic [gcbf_pkg::QUO_W-1:0]          fitness;
  } score_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_chromosome = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic signed [15:0] out_coord_x;
  logic signed [15:0] out_coord_y;
  logic [34:0] out_booth_value;
  logic [16:0] out_fitness_value;

  logic        in_taken = 1'b0;
  logic        idle_on = 1'b1;
  logic [31:0] chrom_q[$];
  score_t      score_q[$];
  int          error_count = 0;
  int          n_accepted = 0;
  int          n_checked = 0;
  int          n_perfect = 0;
  int          cycle_count = 0;
  int          send_gap = 0;
  int          stall_left = 0;

  gray_chromosome_booth_fitness_core #(.CHROMOSOME_BITS(CHROM_BITS)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_chromosome    (in_chromosome),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_coord_x      (out_coord_x),
    .out_coord_y      (out_coord_y),
    .out_booth_value  (out_booth_value),
    .out_fitness_value(out_fitness_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // raw half-word to Q4.12, saturating (only odd lengths can overflow y)
  function automatic logic signed [15:0] to_q412(input logic [63:0] raw);
    logic [63:0] scaled;
    longint      v;
    if (HALF_BITS >= 16) scaled = raw >> (HALF_BITS - 16);
    else scaled = raw << (16 - HALF_BITS);
    v = longint'(scaled) - 32768;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic score_t score_chromosome(input logic [31:0] chrom);
    logic [63:0]       bin;
    longint            ta, tb;
    longint unsigned   booth;
    longint unsigned   fit;
    score_t            sc;
    int                sh;
    bin = 64'(chrom);
    if (CHROM_BITS < 64) bin = bin & ((64'd1 << CHROM_BITS) - 1);
    // prefix XOR from gene 0 down through the whole string
    for (sh = 1; sh < 64; sh = sh << 1) bin = bin ^ (bin >> sh);
    sc.coord_x = to_q412(bin >> LOW_BITS);
    sc.coord_y = to_q412(bin & ((64'd1 << LOW_BITS) - 1));
    ta = longint'(sc.coord_x) + 2 * longint'(sc.coord_y) - 7 * 4096;
    tb = 2 * longint'(sc.coord_x) + longint'(sc.coord_y) - 5 * 4096;
    booth = longint'(ta * ta + tb * tb);
    sc.booth = booth[gcbf_pkg::BOOTH_W-1:0];
    fit = (64'd1 << 40) / ((64'd1 << 24) + booth);
    sc.fitness = fit[gcbf_pkg::QUO_W-1:0];
    return sc;
  endfunction

  function automatic logic [31:0] gray_of(input logic [31:0] bin);
    return bin ^ (bin >> 1);
  endfunction

  task automatic add_chrom(input logic [31:0] chrom);
    chrom_q.insert(chrom_q.size(), chrom);
  endtask

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // sender: holds each transaction until taken, random idle bursts
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap == 0 && idle_on && $urandom_range(0, 5) == 0)
        send_gap = $urandom_range(1, 4);
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (chrom_q.size() == 0) begin
        in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b1;
        in_chromosome <= chrom_q.pop_front();
      end
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 4);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    score_t want;
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               score_q.size());
      $display("** gray_chromosome_booth_fitness_core: FAILED **");
      $finish;
    end
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        score_q.insert(score_q.size(), score_chromosome(in_chromosome));
        n_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (score_q.size() == 0) begin
          $display("[%0t] result transaction with nothing expected", $time);
          error_count++;
        end else begin
          want = score_q.pop_front();
          n_checked++;
          if (want.fitness == 17'd65536) n_perfect++;
          if (out_coord_x !== want.coord_x)
            flag_mismatch("coord_x", longint'(out_coord_x), longint'(want.coord_x));
          if (out_coord_y !== want.coord_y)
            flag_mismatch("coord_y", longint'(out_coord_y), longint'(want.coord_y));
          if (out_booth_value !== want.booth)
            flag_mismatch("booth_value", longint'(out_booth_value), longint'(want.booth));
          if (out_fitness_value !== want.fitness)
            flag_mismatch("fitness_value", longint'(out_fitness_value),
                          longint'(want.fitness));
        end
      end
    end
  end

  task automatic drain();
    while (chrom_q.size() != 0 || in_valid) @(posedge clk);
    while (score_q.size() != 0) @(posedge clk);
  endtask

  // random chromosome: half fully random, half decoded near the optimum at (1, 3)
  task automatic queue_random(input int count);
    logic [15:0] rx, ry;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0, 1: add_chrom($urandom);
        2: begin
          rx = 16'(36864 + $urandom_range(0, 4095) - 2048);
          ry = 16'(45056 + $urandom_range(0, 4095) - 2048);
          add_chrom(gray_of({rx, ry}));
        end
        default: begin
          rx = 16'(36864 + $urandom_range(0, 7) - 4);
          ry = 16'(45056 + $urandom_range(0, 7) - 4);
          add_chrom(gray_of({rx, ry}));
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // directed: raw extremes, decoded corners, perfect score and its neighbors
    add_chrom(32'h0000_0000);
    add_chrom(32'hFFFF_FFFF);
    add_chrom(gray_of({16'hFFFF, 16'hFFFF}));
    add_chrom(gray_of({16'h0000, 16'hFFFF}));
    add_chrom(gray_of({16'hFFFF, 16'h0000}));
    add_chrom(gray_of({16'h8000, 16'h8000}));
    add_chrom(gray_of({16'd36864, 16'd45056}));
    add_chrom(gray_of({16'd36865, 16'd45056}));
    add_chrom(gray_of({16'd36863, 16'd45056}));
    add_chrom(gray_of({16'd36864, 16'd45057}));
    add_chrom(gray_of({16'd36864, 16'd45055}));
    add_chrom(32'h8000_0000);
    add_chrom(32'h0000_0001);
    add_chrom(32'h5555_5555);
    add_chrom(32'hAAAA_AAAA);
    add_chrom(32'h0001_0000);
    add_chrom(32'h0000_8000);
    add_chrom(32'h0000_FFFF);
    add_chrom(32'hFFFF_0000);
    drain();

    queue_random(160);
    drain();
    queue_random(160);
    drain();

    // closing stretch at full rate; let any running stall burst run out first
    idle_on = 1'b0;
    repeat (5) @(posedge clk);
    queue_random(80);
    drain();
    repeat (40) @(posedge clk);

    $display("covered %0d chromosomes: corners, optimum neighborhood and random strings",
             n_accepted);
    $display("%0d results checked, %0d with fitness of exactly one", n_checked, n_perfect);
    if (error_count == 0 && score_q.size() == 0) begin
      $display("** gray_chromosome_booth_fitness_core: PASSED **");
    end else begin
      $display("** gray_chromosome_booth_fitness_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/gcbf_pkg.sv
rtl/core/gcbf_front.sv
rtl/core/gcbf_div_cell.sv
rtl/core/gray_chromosome_booth_fitness_core.sv
verif/tb.sv
